// File: design/vgcd_pkg.sv
// Shared constants, codes and types of the volume gradient block.
package vgcd_pkg;

    localparam int DEF_MAX_X       = 256;
    localparam int DEF_MAX_Y       = 256;
    localparam int DEF_MAX_Z       = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int SAMPLE_W    = 16;
    localparam int GRAD_BITS   = 18;
    localparam int GRAD_MAX    = 131071;
    localparam int GRAD_MIN    = -131072;
    localparam int OUT_TDATA_W = 56;

    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 2;
    localparam int SIZE_RESET   = 256;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_index_t;

    // Where a voxel sits on one axis, which picks the difference formula.
    typedef enum logic [1:0] {
        AXIS_FLAT,
        AXIS_LOW,
        AXIS_HIGH,
        AXIS_MID
    } axis_pos_t;

    typedef struct packed {
        logic      valid;
        logic      emit;
        logic      last;
        logic      mid_fwd;
        axis_pos_t pos_x;
        axis_pos_t pos_y;
        axis_pos_t pos_z;
    } stage_ctl_t;

endpackage

// File: design/vgcd_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports, read-first.
module vgcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr0,
    input  logic [AW-1:0]    rd_addr1,
    output logic [WIDTH-1:0] rd_data0,
    output logic [WIDTH-1:0] rd_data1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data0_reg;
    logic [WIDTH-1:0] rd_data1_reg;

    always_ff @(posedge aclk) begin
        rd_data0_reg <= mem_reg[rd_addr0];
        rd_data1_reg <= mem_reg[rd_addr1];
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// File: design/vgcd_ctrl.sv
// Position counters, window addressing and size registers of the gradient block.
module vgcd_ctrl #(
    parameter int MAX_X       = vgcd_pkg::DEF_MAX_X,
    parameter int MAX_Y       = vgcd_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = vgcd_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgcd_pkg::DEF_SAMPLE_BITS,
    localparam int AW = $clog2(2 * MAX_X * MAX_Y)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vgcd_pkg::CFG_IDX_BITS-1:0] cfg_wr_index,
    input  logic [vgcd_pkg::CFG_BITS-1:0]     cfg_wr_data,
    input  logic                              in_accept,
    input  logic                              in_mode,
    input  logic [vgcd_pkg::SAMPLE_W-1:0]     in_sample,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [SAMPLE_BITS-1:0]            wr_data,
    output logic [AW-1:0]                     rd_mid_addr,
    output logic [AW-1:0]                     rd_zlo_addr,
    output logic [AW-1:0]                     rd_yhi_addr,
    output logic [AW-1:0]                     rd_ylo_addr,
    output vgcd_pkg::stage_ctl_t              s1_ctl,
    output logic [SAMPLE_BITS-1:0]            s1_sample
);

    localparam int XCW = $clog2(MAX_X);
    localparam int YCW = $clog2(MAX_Y);
    localparam int ZCW = $clog2(MAX_Z);

    localparam logic [XCW-1:0] NX_M1_RST =
        XCW'(((vgcd_pkg::SIZE_RESET > MAX_X) ? MAX_X : vgcd_pkg::SIZE_RESET) - 1);
    localparam logic [YCW-1:0] NY_M1_RST =
        YCW'(((vgcd_pkg::SIZE_RESET > MAX_Y) ? MAX_Y : vgcd_pkg::SIZE_RESET) - 1);
    localparam logic [ZCW-1:0] NZ_M1_RST =
        ZCW'(((vgcd_pkg::SIZE_RESET > MAX_Z) ? MAX_Z : vgcd_pkg::SIZE_RESET) - 1);

    // Sizes are held as size minus one, already clamped to 1..MAX.
    logic [XCW-1:0] nx_m1_reg, nx_m1_next;
    logic [YCW-1:0] ny_m1_reg, ny_m1_next;
    logic [ZCW-1:0] nz_m1_reg, nz_m1_next;

    // Write side: position of the newest voxel in the window. After the last
    // sample it keeps counting on flush items, so its slot stays one slice
    // ahead of the output voxel.
    logic [XCW-1:0] wx_reg, wx_next;
    logic [YCW-1:0] wy_reg, wy_next;
    logic [ZCW-1:0] wz_reg, wz_next;
    logic           wpar_reg, wpar_next;
    logic [AW-1:0]  wslot_reg, wslot_next;
    logic           in_done_reg, in_done_next;

    // Read side: position of the next voxel to emit.
    logic [XCW-1:0] qx_reg, qx_next;
    logic [YCW-1:0] qy_reg, qy_next;
    logic [ZCW-1:0] qz_reg, qz_next;
    logic [AW-1:0]  rslot_reg, rslot_next;

    vgcd_pkg::stage_ctl_t   s1_ctl_reg, s1_ctl_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    logic                   cfg_hit;
    logic                   is_sample;
    logic                   do_fill, do_emit_s, do_emit_f, do_write, do_emit, do_act;
    logic                   w_end_row, w_end_slice, last_sample;
    logic                   q_end_row, q_end_slice, q_last;
    logic [AW-1:0]          wslot_inc, rslot_inc, nx_a, mid_addr;
    logic [31:0]            sample_ext;
    logic [SAMPLE_BITS-1:0] sample_val;

    function automatic vgcd_pkg::axis_pos_t axis_pos(logic flat, logic low, logic high);
        vgcd_pkg::axis_pos_t p;
        begin
            if (flat) begin
                p = vgcd_pkg::AXIS_FLAT;
            end else if (low) begin
                p = vgcd_pkg::AXIS_LOW;
            end else if (high) begin
                p = vgcd_pkg::AXIS_HIGH;
            end else begin
                p = vgcd_pkg::AXIS_MID;
            end
            return p;
        end
    endfunction

    // Wider fields are zero extended, narrower ones keep their low bits.
    assign sample_ext = 32'(in_sample);
    assign sample_val = sample_ext[SAMPLE_BITS-1:0];

    always_comb begin
        nx_m1_next = nx_m1_reg;
        ny_m1_next = ny_m1_reg;
        nz_m1_next = nz_m1_reg;
        cfg_hit    = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                vgcd_pkg::CFG_SIZE_X: begin
                    cfg_hit = 1'b1;
                    if (cfg_wr_data == '0) begin
                        nx_m1_next = '0;
                    end else if (32'(cfg_wr_data) > MAX_X) begin
                        nx_m1_next = XCW'(MAX_X - 1);
                    end else begin
                        nx_m1_next = XCW'(cfg_wr_data - 1'b1);
                    end
                end
                vgcd_pkg::CFG_SIZE_Y: begin
                    cfg_hit = 1'b1;
                    if (cfg_wr_data == '0) begin
                        ny_m1_next = '0;
                    end else if (32'(cfg_wr_data) > MAX_Y) begin
                        ny_m1_next = YCW'(MAX_Y - 1);
                    end else begin
                        ny_m1_next = YCW'(cfg_wr_data - 1'b1);
                    end
                end
                vgcd_pkg::CFG_SIZE_Z: begin
                    cfg_hit = 1'b1;
                    if (cfg_wr_data == '0) begin
                        nz_m1_next = '0;
                    end else if (32'(cfg_wr_data) > MAX_Z) begin
                        nz_m1_next = ZCW'(MAX_Z - 1);
                    end else begin
                        nz_m1_next = ZCW'(cfg_wr_data - 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        is_sample = (in_mode == vgcd_pkg::MODE_SAMPLE);
        do_fill   = in_accept && is_sample && !in_done_reg && (wz_reg == '0);
        do_emit_s = in_accept && is_sample && !in_done_reg && (wz_reg != '0);
        do_emit_f = in_accept && !is_sample && in_done_reg;
        do_write  = do_fill || do_emit_s;
        do_emit   = do_emit_s || do_emit_f;
        do_act    = do_write || do_emit_f;

        w_end_row   = (wx_reg == nx_m1_reg);
        w_end_slice = w_end_row && (wy_reg == ny_m1_reg);
        last_sample = w_end_slice && (wz_reg == nz_m1_reg);
        q_end_row   = (qx_reg == nx_m1_reg);
        q_end_slice = q_end_row && (qy_reg == ny_m1_reg);
        q_last      = q_end_slice && (qz_reg == nz_m1_reg);

        // The window holds two slices; slots wrap after an odd slice.
        wslot_inc = (w_end_slice && wpar_reg) ? '0 : wslot_reg + AW'(1);
        rslot_inc = (q_end_slice && qz_reg[0]) ? '0 : rslot_reg + AW'(1);
        nx_a      = AW'(nx_m1_reg) + AW'(1);

        // The mid value of the next voxel is fetched one item ahead. During
        // the fill, slot zero is fetched so the first output finds it.
        mid_addr = do_emit ? rslot_inc : rslot_reg;

        wx_next      = wx_reg;
        wy_next      = wy_reg;
        wz_next      = wz_reg;
        wpar_next    = wpar_reg;
        wslot_next   = wslot_reg;
        in_done_next = in_done_reg;
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        qz_next      = qz_reg;
        rslot_next   = rslot_reg;

        priority if (cfg_hit) begin
            wx_next      = '0;
            wy_next      = '0;
            wz_next      = '0;
            wpar_next    = 1'b0;
            wslot_next   = '0;
            in_done_next = 1'b0;
            qx_next      = '0;
            qy_next      = '0;
            qz_next      = '0;
            rslot_next   = '0;
        end else if (do_emit && q_last) begin
            // Final voxel out: the next sample starts a new volume.
            wx_next      = '0;
            wy_next      = '0;
            wz_next      = '0;
            wpar_next    = 1'b0;
            wslot_next   = '0;
            in_done_next = 1'b0;
            qx_next      = '0;
            qy_next      = '0;
            qz_next      = '0;
            rslot_next   = '0;
        end else begin
            if (do_act) begin
                wslot_next = wslot_inc;
                if (w_end_row) begin
                    wx_next = '0;
                    if (w_end_slice) begin
                        wy_next   = '0;
                        wpar_next = !wpar_reg;
                    end else begin
                        wy_next = wy_reg + YCW'(1);
                    end
                end else begin
                    wx_next = wx_reg + XCW'(1);
                end
            end
            if (do_write && last_sample) begin
                in_done_next = 1'b1;
            end else if (do_write && w_end_slice) begin
                wz_next = wz_reg + ZCW'(1);
            end
            if (do_emit) begin
                rslot_next = rslot_inc;
                if (q_end_row) begin
                    qx_next = '0;
                    if (q_end_slice) begin
                        qy_next = '0;
                        qz_next = qz_reg + ZCW'(1);
                    end else begin
                        qy_next = qy_reg + YCW'(1);
                    end
                end else begin
                    qx_next = qx_reg + XCW'(1);
                end
            end
        end

        s1_ctl_next.valid   = do_act;
        s1_ctl_next.emit    = do_emit;
        s1_ctl_next.last    = q_last;
        s1_ctl_next.mid_fwd = do_write && (mid_addr == wslot_reg);
        s1_ctl_next.pos_x   = axis_pos(nx_m1_reg == '0, qx_reg == '0, qx_reg == nx_m1_reg);
        s1_ctl_next.pos_y   = axis_pos(ny_m1_reg == '0, qy_reg == '0, qy_reg == ny_m1_reg);
        s1_ctl_next.pos_z   = axis_pos(nz_m1_reg == '0, qz_reg == '0, qz_reg == nz_m1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_m1_reg   <= NX_M1_RST;
            ny_m1_reg   <= NY_M1_RST;
            nz_m1_reg   <= NZ_M1_RST;
            wx_reg      <= '0;
            wy_reg      <= '0;
            wz_reg      <= '0;
            wpar_reg    <= 1'b0;
            wslot_reg   <= '0;
            in_done_reg <= 1'b0;
            qx_reg      <= '0;
            qy_reg      <= '0;
            qz_reg      <= '0;
            rslot_reg   <= '0;
            s1_ctl_reg  <= '0;
        end else begin
            nx_m1_reg   <= nx_m1_next;
            ny_m1_reg   <= ny_m1_next;
            nz_m1_reg   <= nz_m1_next;
            wx_reg      <= wx_next;
            wy_reg      <= wy_next;
            wz_reg      <= wz_next;
            wpar_reg    <= wpar_next;
            wslot_reg   <= wslot_next;
            in_done_reg <= in_done_next;
            qx_reg      <= qx_next;
            qy_reg      <= qy_next;
            qz_reg      <= qz_next;
            rslot_reg   <= rslot_next;
            s1_ctl_reg  <= s1_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_sample_reg <= sample_val;
    end

    // The lower z neighbor sits in the slot being written; the RAM reads
    // before it writes, so the old voxel comes back.
    assign wr_en       = do_write;
    assign wr_addr     = wslot_reg;
    assign wr_data     = sample_val;
    assign rd_mid_addr = mid_addr;
    assign rd_zlo_addr = wslot_reg;
    assign rd_yhi_addr = rslot_reg + nx_a;
    assign rd_ylo_addr = rslot_reg - nx_a;
    assign s1_ctl      = s1_ctl_reg;
    assign s1_sample   = s1_sample_reg;

endmodule

// File: design/vgcd_grad.sv
// Gradient arithmetic, x neighbor registers and output queue of the gradient block.
module vgcd_grad #(
    parameter int SAMPLE_BITS = vgcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vgcd_pkg::stage_ctl_t                s1_ctl,
    input  logic [SAMPLE_BITS-1:0]              s1_sample,
    input  logic [SAMPLE_BITS-1:0]              mid_rd,
    input  logic [SAMPLE_BITS-1:0]              zlo_rd,
    input  logic [SAMPLE_BITS-1:0]              yhi_rd,
    input  logic [SAMPLE_BITS-1:0]              ylo_rd,
    output logic                                take_ok,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vgcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);

    localparam int GB = vgcd_pkg::GRAD_BITS;
    localparam int CW = (SAMPLE_BITS + 2 > GB) ? SAMPLE_BITS + 2 : GB;
    localparam int RW = 3 * GB + 1;
    localparam int FIFO_DEPTH = 3;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [CW-1:0] SAT_HI = CW'(vgcd_pkg::GRAD_MAX);
    localparam logic signed [CW-1:0] SAT_LO = CW'(vgcd_pkg::GRAD_MIN);

    logic signed [SAMPLE_BITS-1:0] mid_reg, prev_reg;
    logic signed [SAMPLE_BITS-1:0] next_val;
    logic signed [CW-1:0]          gx, gy, gz;
    logic [RW-1:0]                 entry;

    logic [RW-1:0] fifo_reg [FIFO_DEPTH];
    logic [PW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          push, pop;
    logic [RW-1:0] head_entry;

    function automatic logic signed [CW-1:0] axis_grad(vgcd_pkg::axis_pos_t pos,
                                                       logic signed [SAMPLE_BITS-1:0] lo,
                                                       logic signed [SAMPLE_BITS-1:0] md,
                                                       logic signed [SAMPLE_BITS-1:0] hi);
        logic signed [CW-1:0] l, m, h, g;
        begin
            l = CW'(lo);
            m = CW'(md);
            h = CW'(hi);
            unique case (pos)
                vgcd_pkg::AXIS_FLAT: g = '0;
                vgcd_pkg::AXIS_LOW:  g = (h - m) <<< 1;
                vgcd_pkg::AXIS_HIGH: g = (m - l) <<< 1;
                vgcd_pkg::AXIS_MID:  g = h - l;
            endcase
            return g;
        end
    endfunction

    function automatic logic [GB-1:0] saturate(logic signed [CW-1:0] g);
        logic signed [CW-1:0] s;
        begin
            if (g > SAT_HI) begin
                s = SAT_HI;
            end else if (g < SAT_LO) begin
                s = SAT_LO;
            end else begin
                s = g;
            end
            return s[GB-1:0];
        end
    endfunction

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // The voxel after the output one was fetched in this item; when it was
    // written in the same item the RAM still held the old word.
    assign next_val = s1_ctl.mid_fwd ? s1_sample : mid_rd;

    always_comb begin
        gx    = axis_grad(s1_ctl.pos_x, prev_reg, mid_reg, next_val);
        gy    = axis_grad(s1_ctl.pos_y, ylo_rd, mid_reg, yhi_rd);
        gz    = axis_grad(s1_ctl.pos_z, zlo_rd, mid_reg, s1_sample);
        entry = {s1_ctl.last, saturate(gz), saturate(gy), saturate(gx)};
    end

    always_ff @(posedge aclk) begin
        if (s1_ctl.valid) begin
            prev_reg <= mid_reg;
            mid_reg  <= next_val;
        end
    end

    assign push       = s1_ctl.valid && s1_ctl.emit;
    assign pop        = m_tvalid && m_tready;
    assign head_entry = fifo_reg[head_reg];

    always_comb begin
        head_next = pop ? ptr_inc(head_reg) : head_reg;
        tail_next = push ? ptr_inc(tail_reg) : tail_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + NW'(1);
            2'b01:   cnt_next = cnt_reg - NW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[tail_reg] <= entry;
        end
    end

    // Room must remain for the queued results, the one now in flight and a new one.
    assign take_ok  = ((NW + 1)'(cnt_reg) + (NW + 1)'(push)) <= (NW + 1)'(FIFO_DEPTH - 1);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {{(vgcd_pkg::OUT_TDATA_W - 3 * GB){1'b0}}, head_entry[3*GB-1:0]};
    assign m_tlast  = head_entry[RW-1];

endmodule

// File: design/volume_gradient_central_difference.sv
// Top level of the streamed 3D central-difference gradient block.
//
// Voxels of a volume arrive in raster order (x fastest) on the s_ stream,
// one sample item each; once every sample is in, flush items drain the last
// slice. Every voxel yields one gradient result in half-sample units:
// central differences inside the volume, doubled one-sided differences on a
// face, zero on an axis of size one. A voxel is emitted when the voxel one
// slice after it arrives, so the first result follows the first
// size_x*size_y samples. The block takes one item per cycle while the
// output is ready; results pass the stage-one registers and output queue.
// The rate is set by the window store, two copies of a 2*MAX_X*MAX_Y word
// RAM with two read ports each, serving the y, lower z and upper x neighbors
// in one access, lower x from a register. The store needs no clearing pass
// after reset. A write of any size register restarts the volume.
module volume_gradient_central_difference #(
    parameter int MAX_X       = vgcd_pkg::DEF_MAX_X,
    parameter int MAX_Y       = vgcd_pkg::DEF_MAX_Y,
    parameter int MAX_Z       = vgcd_pkg::DEF_MAX_Z,
    parameter int SAMPLE_BITS = vgcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [vgcd_pkg::CFG_IDX_BITS-1:0] cfg_wr_index,
    input  logic [vgcd_pkg::CFG_BITS-1:0]     cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vgcd_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
    input  logic                              s_tuser,   // [0] mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vgcd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [17:0] grad_x, [35:18] grad_y,
                                                         // [53:36] grad_z, [55:54] zero
    output logic                              m_tlast    // last_voxel
);

    localparam int DEPTH = 2 * MAX_X * MAX_Y;
    localparam int AW    = $clog2(DEPTH);

    logic                   in_accept;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [AW-1:0]          rd_mid_addr, rd_zlo_addr, rd_yhi_addr, rd_ylo_addr;
    logic [SAMPLE_BITS-1:0] mid_rd, zlo_rd, yhi_rd, ylo_rd;
    vgcd_pkg::stage_ctl_t   s1_ctl;
    logic [SAMPLE_BITS-1:0] s1_sample;
    logic                   take_ok;

    assign s_tready  = take_ok;
    assign in_accept = s_tvalid && s_tready;

    vgcd_ctrl #(
        .MAX_X       (MAX_X),
        .MAX_Y       (MAX_Y),
        .MAX_Z       (MAX_Z),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_accept    (in_accept),
        .in_mode      (s_tuser),
        .in_sample    (s_tdata),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_mid_addr  (rd_mid_addr),
        .rd_zlo_addr  (rd_zlo_addr),
        .rd_yhi_addr  (rd_yhi_addr),
        .rd_ylo_addr  (rd_ylo_addr),
        .s1_ctl       (s1_ctl),
        .s1_sample    (s1_sample)
    );

    // Both copies take every write; one serves the x and z taps, the other y.
    vgcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_xz (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_mid_addr),
        .rd_addr1 (rd_zlo_addr),
        .rd_data0 (mid_rd),
        .rd_data1 (zlo_rd)
    );

    vgcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram_y (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_yhi_addr),
        .rd_addr1 (rd_ylo_addr),
        .rd_data0 (yhi_rd),
        .rd_data1 (ylo_rd)
    );

    vgcd_grad #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_ctl    (s1_ctl),
        .s1_sample (s1_sample),
        .mid_rd    (mid_rd),
        .zlo_rd    (zlo_rd),
        .yhi_rd    (yhi_rd),
        .ylo_rd    (ylo_rd),
        .take_ok   (take_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
